// ----- rtl/core/sfr_pkg.sv -----
// Shared types and constants for the servo frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  // Byte count register width (holds counts up to 127)
  localparam int CNT_W     = 7;
  localparam int BYTE_W    = 8;
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  // Header length: two sync bytes, id, length
  localparam int HDR_BYTES = 4;

  typedef enum logic {
    ST_RECV,
    ST_REPLAY
  } sfr_state_t;

endpackage

// ----- rtl/core/sfr_store.sv -----
// Frame store: single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds until the next read; uses sfr_pkg.
module sfr_store
  import sfr_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/servo_frame_receiver_core.sv -----
// Replay start: after a frame's checksum byte is accepted, its first output item passes
// through the replay state register, the store's read register and the output register.
// Throughput: one byte per cycle in, then a good frame of L+4 bytes is replayed at one
// byte per cycle unless stalled, via the store's single read port, input held off meanwhile.
// Reset (rst_n, synchronous, active low) clears count, sum, state and output valid;
// the frame store is not cleared and needs no sweep.
module servo_frame_receiver_core
  import sfr_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] frame_byte
  output logic       out_tlast   // frame_last
);

  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  sfr_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] running_sum_r, running_sum_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  frame_len_r, frame_len_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  lim;
  logic [BYTE_W-1:0] b;
  logic              start_replay;
  logic              rd_en;
  logic              load;
  logic              rd_issue;
  logic              issue_last;
  logic [BYTE_W-1:0] rd_data;

  assign in_fire = in_tvalid && in_tready;
  assign b       = in_tdata;

  // Write position; out-of-range count folds back to zero
  assign cnt_cur = (byte_count_r >= CNT_W'(MAX_FRAME)) ? '0 : byte_count_r;
  assign n       = cnt_cur + CNT_W'(1);
  assign lim     = len_r + CNT_W'(HDR_BYTES);

  // Frame parsing on each accepted byte
  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    len_nxt         = len_r;
    frame_len_nxt   = frame_len_r;
    start_replay    = 1'b0;
    if (in_fire) begin
      byte_count_nxt = n;
      if (n <= CNT_W'(2)) begin
        if (b != SYNC_BYTE) begin
          byte_count_nxt = '0;
        end
      end else if (n == CNT_W'(3)) begin
        running_sum_nxt = b;
      end else if (n == CNT_W'(HDR_BYTES)) begin
        if (b > BYTE_W'(MAX_FRAME - HDR_BYTES)) begin
          byte_count_nxt = '0;
        end else begin
          running_sum_nxt = running_sum_r + b;
          len_nxt         = b[CNT_W-1:0];
        end
      end else if (n < lim) begin
        running_sum_nxt = running_sum_r + b;
      end else begin
        // End of frame or overrun
        byte_count_nxt = '0;
        if ((n == lim) && (b == ~running_sum_r)) begin
          start_replay  = 1'b1;
          frame_len_nxt = n;
        end
      end
    end
  end

  // Replay pipeline: read issue, pending read data, output register
  assign load       = pend_r && (!out_valid_r || out_tready);
  assign rd_issue   = (state_r == ST_REPLAY) && (!pend_r || load);
  assign issue_last = ((CNT_W'(rd_addr_r) + CNT_W'(1)) == frame_len_r);

  always_comb begin
    rd_addr_nxt   = rd_addr_r;
    pend_last_nxt = pend_last_r;
    pend_nxt      = pend_r;
    if (rd_issue) begin
      rd_addr_nxt   = issue_last ? '0 : rd_addr_r + AW'(1);
      pend_last_nxt = issue_last;
      pend_nxt      = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_data;
      out_last_nxt  = pend_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RECV: begin
        if (start_replay) begin
          state_nxt = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (rd_issue && issue_last) begin
          state_nxt = ST_RECV;
        end
      end
      default: state_nxt = ST_RECV;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_RECV:   in_tready = 1'b1;
      ST_REPLAY: rd_en     = rd_issue;
      default: begin
        in_tready = 1'b0;
        rd_en     = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RECV;
      byte_count_r  <= '0;
      running_sum_r <= '0;
      rd_addr_r     <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      rd_addr_r     <= rd_addr_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    frame_len_r <= frame_len_nxt;
    pend_last_r <= pend_last_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  sfr_store #(
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (cnt_cur[AW-1:0]),
    .wr_data (b),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/sfr_checker.sv -----
// Port-level checks for servo_frame_receiver_core, attached by bind.
// Watches the handshake ports only; uses sfr_pkg.
module sfr_checker
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic [CNT_W-1:0] beat_r;
  logic             out_fire;

  assign out_fire = out_tvalid && out_tready;

  // Position of the next output item within its frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (out_fire) begin
      beat_r <= out_tlast ? '0 : beat_r + CNT_W'(1);
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // Replayed frames start with two sync bytes
  a_sync0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (beat_r == CNT_W'(0)) |-> out_tdata == SYNC_BYTE)
    else $error("first frame byte is not sync");

  a_sync1: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (beat_r == CNT_W'(1)) |-> out_tdata == SYNC_BYTE)
    else $error("second frame byte is not sync");

  // A frame holds the header and at least the checksum
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> beat_r >= CNT_W'(HDR_BYTES))
    else $error("frame ended before header and checksum");

endmodule

bind servo_frame_receiver_core sfr_checker u_sfr_checker (.*);
